// ----- sv/sbid_pkg.sv -----
// Package for the sixteen-bit instruction decoder: opcode tables, mask constants,
// mnemonic bases, layout codes and the extension-word helper.
// Has no dependencies; imported by sixteen_bit_insn_decoder_unit and its testbench.
package sbid_pkg;

   typedef logic [6:0]  mnem_type;
   typedef logic [3:0]  layout_type;
   typedef logic [15:0] word_type;

   localparam word_type MASK_ONE     = 16'o177700;
   localparam word_type MASK_TWO     = 16'o170000;
   localparam word_type MASK_REGOP   = 16'o177000;
   localparam word_type MASK_REG     = 16'o177770;
   localparam word_type MASK_BR      = 16'o177400;
   localparam word_type ADDR_UNKNOWN = 16'hFFFF;

   localparam int NUM_ONE   = 30;
   localparam int NUM_TWO   = 12;
   localparam int NUM_REGOP = 7;
   localparam int NUM_REG   = 5;
   localparam int NUM_BR    = 17;
   localparam int NUM_EXACT = 21;

   localparam mnem_type BASE_ONE   = 7'd0;
   localparam mnem_type BASE_TWO   = 7'd30;
   localparam mnem_type BASE_REGOP = 7'd42;
   localparam mnem_type BASE_REG   = 7'd49;
   localparam mnem_type BASE_BR    = 7'd54;
   localparam mnem_type BASE_EXACT = 7'd71;
   localparam mnem_type MN_MARK    = 7'd29;
   localparam mnem_type MN_SOB     = 7'd44;
   localparam mnem_type MN_EMT     = 7'd69;
   localparam mnem_type MN_UNKNOWN = 7'd92;

   localparam layout_type LAY_NONE    = 4'd0;
   localparam layout_type LAY_ONE     = 4'd1;
   localparam layout_type LAY_TWO     = 4'd2;
   localparam layout_type LAY_REG_OP  = 4'd3;
   localparam layout_type LAY_OP_REG  = 4'd4;
   localparam layout_type LAY_REG     = 4'd5;
   localparam layout_type LAY_BRANCH  = 4'd6;
   localparam layout_type LAY_SOB     = 4'd7;
   localparam layout_type LAY_LITERAL = 4'd8;
   localparam layout_type LAY_UNKNOWN = 4'd9;

   localparam word_type ONE_CODES [NUM_ONE] = '{
      16'o005000, 16'o105000, 16'o005100, 16'o105100, 16'o005200, 16'o105200,
      16'o005300, 16'o105300, 16'o005400, 16'o105400, 16'o005700, 16'o105700,
      16'o006200, 16'o106200, 16'o006300, 16'o106300, 16'o006000, 16'o106000,
      16'o006100, 16'o106100, 16'o000300, 16'o005500, 16'o105500, 16'o005600,
      16'o105600, 16'o006700, 16'o106700, 16'o106400, 16'o000100, 16'o006400
   };
   localparam word_type TWO_CODES [NUM_TWO] = '{
      16'o010000, 16'o110000, 16'o020000, 16'o120000, 16'o060000, 16'o160000,
      16'o030000, 16'o130000, 16'o040000, 16'o140000, 16'o050000, 16'o150000
   };
   localparam word_type REGOP_CODES [NUM_REGOP] = '{
      16'o074000, 16'o004000, 16'o077000, 16'o070000, 16'o071000, 16'o072000,
      16'o073000
   };
   localparam word_type REG_CODES [NUM_REG] = '{
      16'o000200, 16'o075000, 16'o075010, 16'o075020, 16'o075030
   };
   localparam word_type BR_CODES [NUM_BR] = '{
      16'o000400, 16'o001000, 16'o001400, 16'o100000, 16'o100400, 16'o102000,
      16'o102400, 16'o103000, 16'o103400, 16'o002000, 16'o002400, 16'o003000,
      16'o003400, 16'o101000, 16'o101400, 16'o104000, 16'o104400
   };
   localparam word_type EXACT_CODES [NUM_EXACT] = '{
      16'o000003, 16'o000004, 16'o000002, 16'o000006, 16'o000000, 16'o000001,
      16'o000005, 16'o000240, 16'o000241, 16'o000242, 16'o000243, 16'o000244,
      16'o000250, 16'o000257, 16'o000260, 16'o000261, 16'o000262, 16'o000263,
      16'o000264, 16'o000270, 16'o000277
   };

   // An operand needs an extension word for index modes and for immediate or
   // absolute addressing through the program counter.
   function automatic logic ext_word(input logic [2:0] mode, input logic [2:0] rnum);
      ext_word = (mode == 3'd6) || (mode == 3'd7) ||
                 ((rnum == 3'd7) && ((mode == 3'd2) || (mode == 3'd3)));
   endfunction

endpackage

// ----- sv/sixteen_bit_insn_decoder_unit.sv -----
// Throughput is one beat per cycle while the output is not stalled; the three register
// stages hold the opcode group matches, the mnemonic and layout, and the extracted
// fields with the 16-bit target. Stages advance independently, so bubbles close up
// while the output stalls. Synchronous active-high reset clears all stage valid bits;
// payload registers are not reset.
module sixteen_bit_insn_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_opcode_word,
   input  logic [15:0]            req_insn_address,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sbid_pkg::mnem_type     rsp_mnemonic,
   output sbid_pkg::layout_type   rsp_layout,
   output logic [2:0]             rsp_src_amode,
   output logic [2:0]             rsp_src_reg,
   output logic [2:0]             rsp_dst_amode,
   output logic [2:0]             rsp_dst_reg,
   output logic [2:0]             rsp_reg_field,
   output logic [7:0]             rsp_literal,
   output logic signed [8:0]      rsp_branch_offset,
   output logic [15:0]            rsp_target_address,
   output logic                   rsp_relative,
   output logic [1:0]             rsp_length_words
);
   import sbid_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   word_type    s1_word_ff, s1_addr_ff;
   logic        s1_one_hit_ff, s1_two_hit_ff, s1_regop_hit_ff;
   logic        s1_reg_hit_ff, s1_br_hit_ff, s1_exact_hit_ff;
   logic [4:0]  s1_one_idx_ff, s1_two_idx_ff, s1_regop_idx_ff;
   logic [4:0]  s1_reg_idx_ff, s1_br_idx_ff, s1_exact_idx_ff;
   logic        s2_valid_ff, s2_valid_in;
   word_type    s2_word_ff, s2_addr_ff;
   mnem_type    s2_mn_ff, s2_mn_in;
   layout_type  s2_lay_ff, s2_lay_in;
   logic        s3_valid_ff, s3_valid_in;
   word_type    s3_word_ff;
   mnem_type    s3_mn_ff;
   layout_type  s3_lay_ff;
   logic [2:0]  s3_regf_ff, s3_regf_in;
   logic [7:0]  s3_lit_ff, s3_lit_in;
   logic [8:0]  s3_off_ff, s3_off_in;
   word_type    s3_tgt_ff, s3_tgt_in;
   logic        s3_rel_ff, s3_rel_in;
   logic [1:0]  s3_len_ff, s3_len_in;

   logic        en1, en2, en3;

   logic        s1_one_hit_in, s1_two_hit_in, s1_regop_hit_in;
   logic        s1_reg_hit_in, s1_br_hit_in, s1_exact_hit_in;
   logic [4:0]  s1_one_idx_in, s1_two_idx_in, s1_regop_idx_in;
   logic [4:0]  s1_reg_idx_in, s1_br_idx_in, s1_exact_idx_in;

   logic [2:0]  sm2, sr2, dm2, dr2;
   logic [8:0]  sob_dist;
   word_type    tgt_sum;

   assign en3 = !s3_valid_ff || !rsp_stall;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = !en1;

   assign s1_valid_in = en1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = en3 ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      s1_one_hit_in = 1'b0;   s1_one_idx_in = '0;
      s1_two_hit_in = 1'b0;   s1_two_idx_in = '0;
      s1_regop_hit_in = 1'b0; s1_regop_idx_in = '0;
      s1_reg_hit_in = 1'b0;   s1_reg_idx_in = '0;
      s1_br_hit_in = 1'b0;    s1_br_idx_in = '0;
      s1_exact_hit_in = 1'b0; s1_exact_idx_in = '0;
      for (int i = 0; i < NUM_ONE; i++) begin
         if (ONE_CODES[i] == (req_opcode_word & MASK_ONE)) begin
            s1_one_hit_in = 1'b1;
            s1_one_idx_in = 5'(i);
         end
      end
      for (int i = 0; i < NUM_TWO; i++) begin
         if (TWO_CODES[i] == (req_opcode_word & MASK_TWO)) begin
            s1_two_hit_in = 1'b1;
            s1_two_idx_in = 5'(i);
         end
      end
      for (int i = 0; i < NUM_REGOP; i++) begin
         if (REGOP_CODES[i] == (req_opcode_word & MASK_REGOP)) begin
            s1_regop_hit_in = 1'b1;
            s1_regop_idx_in = 5'(i);
         end
      end
      for (int i = 0; i < NUM_REG; i++) begin
         if (REG_CODES[i] == (req_opcode_word & MASK_REG)) begin
            s1_reg_hit_in = 1'b1;
            s1_reg_idx_in = 5'(i);
         end
      end
      for (int i = 0; i < NUM_BR; i++) begin
         if (BR_CODES[i] == (req_opcode_word & MASK_BR)) begin
            s1_br_hit_in = 1'b1;
            s1_br_idx_in = 5'(i);
         end
      end
      for (int i = 0; i < NUM_EXACT; i++) begin
         if (EXACT_CODES[i] == req_opcode_word) begin
            s1_exact_hit_in = 1'b1;
            s1_exact_idx_in = 5'(i);
         end
      end
   end

   always_comb begin
      s2_mn_in  = MN_UNKNOWN;
      s2_lay_in = LAY_UNKNOWN;
      if (s1_one_hit_ff) begin
         s2_mn_in  = BASE_ONE + {2'b00, s1_one_idx_ff};
         s2_lay_in = (s2_mn_in == MN_MARK) ? LAY_LITERAL : LAY_ONE;
      end else if (s1_two_hit_ff) begin
         s2_mn_in  = BASE_TWO + {2'b00, s1_two_idx_ff};
         s2_lay_in = LAY_TWO;
      end else if (s1_regop_hit_ff) begin
         s2_mn_in  = BASE_REGOP + {2'b00, s1_regop_idx_ff};
         if (s2_mn_in == MN_SOB) begin
            s2_lay_in = LAY_SOB;
         end else if (s2_mn_in < MN_SOB) begin
            s2_lay_in = LAY_REG_OP;
         end else begin
            s2_lay_in = LAY_OP_REG;
         end
      end else if (s1_reg_hit_ff) begin
         s2_mn_in  = BASE_REG + {2'b00, s1_reg_idx_ff};
         s2_lay_in = LAY_REG;
      end else if (s1_br_hit_ff) begin
         s2_mn_in  = BASE_BR + {2'b00, s1_br_idx_ff};
         s2_lay_in = (s2_mn_in >= MN_EMT) ? LAY_LITERAL : LAY_BRANCH;
      end else if (s1_exact_hit_ff) begin
         s2_mn_in  = BASE_EXACT + {2'b00, s1_exact_idx_ff};
         s2_lay_in = LAY_NONE;
      end
   end

   assign sm2 = s2_word_ff[11:9];
   assign sr2 = s2_word_ff[8:6];
   assign dm2 = s2_word_ff[5:3];
   assign dr2 = s2_word_ff[2:0];
   assign sob_dist = {2'b00, s2_word_ff[5:0], 1'b0};

   always_comb begin
      s3_regf_in = 3'd0;
      s3_lit_in  = 8'd0;
      s3_off_in  = 9'd0;
      s3_rel_in  = 1'b0;
      s3_len_in  = 2'd1;
      case (s2_lay_ff)
         LAY_ONE, LAY_REG_OP, LAY_OP_REG: begin
            s3_len_in = 2'd1 + {1'b0, ext_word(dm2, dr2)};
            if (s2_lay_ff != LAY_ONE) begin
               s3_regf_in = sr2;
            end
         end
         LAY_TWO: begin
            s3_len_in = 2'd1 + {1'b0, ext_word(sm2, sr2)} + {1'b0, ext_word(dm2, dr2)};
         end
         LAY_SOB: begin
            s3_regf_in = sr2;
            s3_off_in  = 9'd0 - sob_dist;
         end
         LAY_REG: begin
            s3_regf_in = dr2;
         end
         LAY_BRANCH: begin
            s3_off_in = {s2_word_ff[7:0], 1'b0};
            s3_rel_in = (s2_addr_ff == ADDR_UNKNOWN);
         end
         LAY_LITERAL: begin
            s3_lit_in = (s2_mn_ff == MN_MARK) ? {2'b00, s2_word_ff[5:0]} : s2_word_ff[7:0];
         end
         default: begin
            s3_regf_in = 3'd0;
         end
      endcase
   end

   assign tgt_sum = s2_addr_ff + 16'd2 + {{7{s3_off_in[8]}}, s3_off_in};
   assign s3_tgt_in = ((s2_lay_ff == LAY_SOB) || ((s2_lay_ff == LAY_BRANCH) && !s3_rel_in))
                      ? tgt_sum : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_word_ff      <= req_opcode_word;
         s1_addr_ff      <= req_insn_address;
         s1_one_hit_ff   <= s1_one_hit_in;
         s1_two_hit_ff   <= s1_two_hit_in;
         s1_regop_hit_ff <= s1_regop_hit_in;
         s1_reg_hit_ff   <= s1_reg_hit_in;
         s1_br_hit_ff    <= s1_br_hit_in;
         s1_exact_hit_ff <= s1_exact_hit_in;
         s1_one_idx_ff   <= s1_one_idx_in;
         s1_two_idx_ff   <= s1_two_idx_in;
         s1_regop_idx_ff <= s1_regop_idx_in;
         s1_reg_idx_ff   <= s1_reg_idx_in;
         s1_br_idx_ff    <= s1_br_idx_in;
         s1_exact_idx_ff <= s1_exact_idx_in;
      end
      if (en2) begin
         s2_word_ff <= s1_word_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_mn_ff   <= s2_mn_in;
         s2_lay_ff  <= s2_lay_in;
      end
      if (en3) begin
         s3_word_ff <= s2_word_ff;
         s3_mn_ff   <= s2_mn_ff;
         s3_lay_ff  <= s2_lay_ff;
         s3_regf_ff <= s3_regf_in;
         s3_lit_ff  <= s3_lit_in;
         s3_off_ff  <= s3_off_in;
         s3_tgt_ff  <= s3_tgt_in;
         s3_rel_ff  <= s3_rel_in;
         s3_len_ff  <= s3_len_in;
      end
   end

   assign rsp_valid          = s3_valid_ff;
   assign rsp_mnemonic       = s3_mn_ff;
   assign rsp_layout         = s3_lay_ff;
   assign rsp_src_amode      = s3_word_ff[11:9];
   assign rsp_src_reg        = s3_word_ff[8:6];
   assign rsp_dst_amode      = s3_word_ff[5:3];
   assign rsp_dst_reg        = s3_word_ff[2:0];
   assign rsp_reg_field      = s3_regf_ff;
   assign rsp_literal        = s3_lit_ff;
   assign rsp_branch_offset  = s3_off_ff;
   assign rsp_target_address = s3_tgt_ff;
   assign rsp_relative       = s3_rel_ff;
   assign rsp_length_words   = s3_len_ff;

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("Accepted request beat did not enter the first stage.");

   a_unknown_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_layout == LAY_UNKNOWN)) |->
      ((rsp_mnemonic == MN_UNKNOWN) && (rsp_length_words == 2'd1) &&
       (rsp_literal == 8'd0) && (rsp_target_address == 16'd0)))
      else $error("Unknown opcode carries decoded fields.");

   a_relative_branch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_relative) |->
      ((rsp_layout == LAY_BRANCH) && (rsp_target_address == 16'd0)))
      else $error("Relative flag set outside a branch or with a target.");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_length_words != 2'd0) &&
                     ((rsp_length_words == 2'd1) || (rsp_layout == LAY_ONE) ||
                      (rsp_layout == LAY_TWO) || (rsp_layout == LAY_REG_OP) ||
                      (rsp_layout == LAY_OP_REG))))
      else $error("Instruction length inconsistent with its layout.");
`endif

endmodule

// ----- bench/sixteen_bit_insn_decoder_unit_tb.sv -----
// Self-checking testbench for sixteen_bit_insn_decoder_unit: directed opcode table, then
// random instruction words under several idle and stall mixes, checked against a decoder model.
// Depends on sbid_pkg and the decoder RTL only.
module sixteen_bit_insn_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbid_pkg::*;

   localparam int       NUM_MNEMONICS = 92;
   localparam mnem_type MN_BR         = BASE_BR;
   localparam mnem_type MN_TRAP       = MN_EMT + 7'd1;
   localparam mnem_type MN_HALT       = BASE_EXACT + 7'd4;

   typedef struct packed {
      mnem_type    mnemonic;
      layout_type  layout;
      logic [2:0]  src_amode;
      logic [2:0]  src_reg;
      logic [2:0]  dst_amode;
      logic [2:0]  dst_reg;
      logic [2:0]  reg_field;
      logic [7:0]  literal;
      logic [8:0]  branch_offset;
      logic [15:0] target_address;
      logic        relative;
      logic [1:0]  length_words;
   } decoded_type;

   typedef struct packed {
      word_type    word;
      word_type    addr;
      logic        typed;
      decoded_type want;
   } directed_row_type;

   localparam decoded_type NO_TYPED_RESULT = '0;

   localparam word_type OPCODE_LIST [NUM_MNEMONICS] = '{
      16'o005000, 16'o105000, 16'o005100, 16'o105100, 16'o005200, 16'o105200,
      16'o005300, 16'o105300, 16'o005400, 16'o105400, 16'o005700, 16'o105700,
      16'o006200, 16'o106200, 16'o006300, 16'o106300, 16'o006000, 16'o106000,
      16'o006100, 16'o106100, 16'o000300, 16'o005500, 16'o105500, 16'o005600,
      16'o105600, 16'o006700, 16'o106700, 16'o106400, 16'o000100, 16'o006400,
      16'o010000, 16'o110000, 16'o020000, 16'o120000, 16'o060000, 16'o160000,
      16'o030000, 16'o130000, 16'o040000, 16'o140000, 16'o050000, 16'o150000,
      16'o074000, 16'o004000, 16'o077000, 16'o070000, 16'o071000, 16'o072000,
      16'o073000,
      16'o000200, 16'o075000, 16'o075010, 16'o075020, 16'o075030,
      16'o000400, 16'o001000, 16'o001400, 16'o100000, 16'o100400, 16'o102000,
      16'o102400, 16'o103000, 16'o103400, 16'o002000, 16'o002400, 16'o003000,
      16'o003400, 16'o101000, 16'o101400, 16'o104000, 16'o104400,
      16'o000003, 16'o000004, 16'o000002, 16'o000006, 16'o000000, 16'o000001,
      16'o000005, 16'o000240, 16'o000241, 16'o000242, 16'o000243, 16'o000244,
      16'o000250, 16'o000257, 16'o000260, 16'o000261, 16'o000262, 16'o000263,
      16'o000264, 16'o000270, 16'o000277
   };

   localparam directed_row_type DIRECTED_WORDS [26] = '{
      '{16'o000000, 16'h0000, 1'b1, '{MN_HALT, LAY_NONE, 3'd0, 3'd0, 3'd0, 3'd0,
                                      3'd0, 8'd0, 9'd0, 16'd0, 1'b0, 2'd1}},
      '{16'o177777, 16'hFFFF, 1'b1, '{MN_UNKNOWN, LAY_UNKNOWN, 3'd7, 3'd7, 3'd7, 3'd7,
                                      3'd0, 8'd0, 9'd0, 16'd0, 1'b0, 2'd1}},
      '{16'o170000, 16'h1234, 1'b1, '{MN_UNKNOWN, LAY_UNKNOWN, 3'd0, 3'd0, 3'd0, 3'd0,
                                      3'd0, 8'd0, 9'd0, 16'd0, 1'b0, 2'd1}},
      '{16'o104000, 16'h0000, 1'b1, '{MN_EMT, LAY_LITERAL, 3'd4, 3'd0, 3'd0, 3'd0,
                                      3'd0, 8'd0, 9'd0, 16'd0, 1'b0, 2'd1}},
      '{16'o104777, 16'hFFFF, 1'b1, '{MN_TRAP, LAY_LITERAL, 3'd4, 3'd7, 3'd7, 3'd7,
                                      3'd0, 8'd255, 9'd0, 16'd0, 1'b0, 2'd1}},
      '{16'o000600, 16'hFFFF, 1'b1, '{MN_BR, LAY_BRANCH, 3'd0, 3'd6, 3'd0, 3'd0,
                                      3'd0, 8'd0, 9'h100, 16'd0, 1'b1, 2'd1}},
      '{16'o000577, 16'hFFFE, 1'b0, NO_TYPED_RESULT},
      '{16'o000400, 16'h0000, 1'b0, NO_TYPED_RESULT},
      '{16'o001600, 16'h0000, 1'b0, NO_TYPED_RESULT},
      '{16'o003777, 16'h0000, 1'b0, NO_TYPED_RESULT},
      '{16'o077077, 16'hFFFF, 1'b0, NO_TYPED_RESULT},
      '{16'o077100, 16'h0000, 1'b0, NO_TYPED_RESULT},
      '{16'o006477, 16'h0100, 1'b0, NO_TYPED_RESULT},
      '{16'o006400, 16'h0200, 1'b0, NO_TYPED_RESULT},
      '{16'o005000, 16'h0000, 1'b0, NO_TYPED_RESULT},
      '{16'o017767, 16'h1000, 1'b0, NO_TYPED_RESULT},
      '{16'o012737, 16'h2000, 1'b0, NO_TYPED_RESULT},
      '{16'o004767, 16'h3000, 1'b0, NO_TYPED_RESULT},
      '{16'o074327, 16'h4000, 1'b0, NO_TYPED_RESULT},
      '{16'o073567, 16'h5000, 1'b0, NO_TYPED_RESULT},
      '{16'o000207, 16'h6000, 1'b0, NO_TYPED_RESULT},
      '{16'o075037, 16'h7000, 1'b0, NO_TYPED_RESULT},
      '{16'o000240, 16'h8000, 1'b0, NO_TYPED_RESULT},
      '{16'o000277, 16'h9000, 1'b0, NO_TYPED_RESULT},
      '{16'o000167, 16'hA000, 1'b0, NO_TYPED_RESULT},
      '{16'o000007, 16'hB000, 1'b0, NO_TYPED_RESULT}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [15:0]          req_opcode_word = '0;
   logic [15:0]          req_insn_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   mnem_type             rsp_mnemonic;
   layout_type           rsp_layout;
   logic [2:0]           rsp_src_amode;
   logic [2:0]           rsp_src_reg;
   logic [2:0]           rsp_dst_amode;
   logic [2:0]           rsp_dst_reg;
   logic [2:0]           rsp_reg_field;
   logic [7:0]           rsp_literal;
   logic signed [8:0]    rsp_branch_offset;
   logic [15:0]          rsp_target_address;
   logic                 rsp_relative;
   logic [1:0]           rsp_length_words;

   decoded_type          pending_decodes [$];
   int unsigned          field_errors = 0;
   int unsigned          send_idle_pct = 0;
   int unsigned          stall_pct = 0;

   sixteen_bit_insn_decoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode_word    (req_opcode_word),
      .req_insn_address   (req_insn_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mnemonic       (rsp_mnemonic),
      .rsp_layout         (rsp_layout),
      .rsp_src_amode      (rsp_src_amode),
      .rsp_src_reg        (rsp_src_reg),
      .rsp_dst_amode      (rsp_dst_amode),
      .rsp_dst_reg        (rsp_dst_reg),
      .rsp_reg_field      (rsp_reg_field),
      .rsp_literal        (rsp_literal),
      .rsp_branch_offset  (rsp_branch_offset),
      .rsp_target_address (rsp_target_address),
      .rsp_relative       (rsp_relative),
      .rsp_length_words   (rsp_length_words)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic word_type group_mask(input int idx);
      if (idx < BASE_TWO) return MASK_ONE;
      if (idx < BASE_REGOP) return MASK_TWO;
      if (idx < BASE_REG) return MASK_REGOP;
      if (idx < BASE_BR) return MASK_REG;
      if (idx < BASE_EXACT) return MASK_BR;
      return 16'hFFFF;
   endfunction

   function automatic logic [1:0] extension_words(input logic [2:0] mode, input logic [2:0] rnum);
      return (mode >= 3'd6 || (rnum == 3'd7 && mode[2:1] == 2'b01)) ? 2'd1 : 2'd0;
   endfunction

   function automatic decoded_type decode_word(input word_type w, input word_type a);
      decoded_type r;
      int          hit;
      int          i;
      logic [6:0]  twice;
      logic [8:0]  disp;
      r = '0;
      r.src_amode = w[11:9];
      r.src_reg = w[8:6];
      r.dst_amode = w[5:3];
      r.dst_reg = w[2:0];
      r.mnemonic = MN_UNKNOWN;
      r.layout = LAY_UNKNOWN;
      r.length_words = 2'd1;
      hit = -1;
      for (i = NUM_MNEMONICS - 1; i >= 0; i--) begin
         if ((w & group_mask(i)) == OPCODE_LIST[i]) hit = i;
      end
      if (hit < 0) return r;
      r.mnemonic = 7'(hit);
      if (hit < BASE_TWO) begin
         if (r.mnemonic == MN_MARK) begin
            r.layout = LAY_LITERAL;
            r.literal = {2'b00, w[5:0]};
         end else begin
            r.layout = LAY_ONE;
            r.length_words = 2'd1 + extension_words(w[5:3], w[2:0]);
         end
      end else if (hit < BASE_REGOP) begin
         r.layout = LAY_TWO;
         r.length_words = 2'd1 + extension_words(w[11:9], w[8:6])
                               + extension_words(w[5:3], w[2:0]);
      end else if (hit < BASE_REG) begin
         r.reg_field = w[8:6];
         if (r.mnemonic == MN_SOB) begin
            twice = {w[5:0], 1'b0};
            r.layout = LAY_SOB;
            r.branch_offset = 9'd0 - {2'b00, twice};
            r.target_address = a + 16'd2 - {9'd0, twice};
         end else begin
            r.layout = (r.mnemonic < MN_SOB) ? LAY_REG_OP : LAY_OP_REG;
            r.length_words = 2'd1 + extension_words(w[5:3], w[2:0]);
         end
      end else if (hit < BASE_BR) begin
         r.layout = LAY_REG;
         r.reg_field = w[2:0];
      end else if (hit < BASE_EXACT) begin
         if (r.mnemonic >= MN_EMT) begin
            r.layout = LAY_LITERAL;
            r.literal = w[7:0];
         end else begin
            disp = {w[7:0], 1'b0};
            r.layout = LAY_BRANCH;
            r.branch_offset = disp;
            if (a == ADDR_UNKNOWN) r.relative = 1'b1;
            else r.target_address = a + 16'd2 + {{7{disp[8]}}, disp};
         end
      end else begin
         r.layout = LAY_NONE;
      end
      return r;
   endfunction

   function automatic word_type random_word();
      int pick;
      if ($urandom_range(99) < 15) return 16'($urandom);
      pick = $urandom_range(NUM_MNEMONICS - 1);
      return OPCODE_LIST[pick] | (16'($urandom) & ~group_mask(pick));
   endfunction

   function automatic word_type random_address();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return ADDR_UNKNOWN;
      if (roll < 15) return 16'hFFFE;
      if (roll < 20) return 16'h0000;
      return 16'($urandom);
   endfunction

   task automatic drive_instruction(input word_type w, input word_type a, input decoded_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode_word <= w;
      req_insn_address <= a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_decodes.push_back(want);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         field_errors++;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_decodes.size() == 0) begin
            $error("response beat with no instruction outstanding");
            field_errors++;
         end else begin
            want = pending_decodes.pop_front();
            compare_field("mnemonic", 32'(want.mnemonic), 32'(rsp_mnemonic));
            compare_field("layout", 32'(want.layout), 32'(rsp_layout));
            compare_field("src_amode", 32'(want.src_amode), 32'(rsp_src_amode));
            compare_field("src_reg", 32'(want.src_reg), 32'(rsp_src_reg));
            compare_field("dst_amode", 32'(want.dst_amode), 32'(rsp_dst_amode));
            compare_field("dst_reg", 32'(want.dst_reg), 32'(rsp_dst_reg));
            compare_field("reg_field", 32'(want.reg_field), 32'(rsp_reg_field));
            compare_field("literal", 32'(want.literal), 32'(rsp_literal));
            compare_field("branch_offset", 32'($signed(want.branch_offset)),
                          32'(rsp_branch_offset));
            compare_field("target_address", 32'(want.target_address),
                          32'(rsp_target_address));
            compare_field("relative", 32'(want.relative), 32'(rsp_relative));
            compare_field("length_words", 32'(want.length_words), 32'(rsp_length_words));
         end
      end
   end

   initial begin
      int       row;
      int       phase;
      int       n;
      word_type w;
      word_type a;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (row = 0; row < $size(DIRECTED_WORDS); row++) begin
         w = DIRECTED_WORDS[row].word;
         a = DIRECTED_WORDS[row].addr;
         drive_instruction(w, a, DIRECTED_WORDS[row].typed ? DIRECTED_WORDS[row].want
                                                            : decode_word(w, a));
      end
      wait_drained();
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 75;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 75;
            end
            default: begin
               send_idle_pct = 20;
               stall_pct = 20;
            end
         endcase
         for (n = 0; n < 300; n++) begin
            w = random_word();
            a = random_address();
            drive_instruction(w, a, decode_word(w, a));
         end
         wait_drained();
      end
      repeat (8) @(posedge clock);
      if (field_errors == 0 && pending_decodes.size() == 0)
         $display("sixteen_bit_insn_decoder_unit verification clean");
      else
         $display("sixteen_bit_insn_decoder_unit verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("sixteen_bit_insn_decoder_unit verification failed");
      $finish;
   end

endmodule
